// ===== rtl/led_blink_breathe_driver_macros.svh =====
// Assertion macros for the LED blink/breathe driver.
// Each macro expects i_clk and i_rst_n in scope at the point of use.
// No other dependencies.
`ifndef LED_BLINK_BREATHE_DRIVER_MACROS_SVH
`define LED_BLINK_BREATHE_DRIVER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define LBBD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define LBBD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LBBD_ASSERT_NOW(lbl, ante, cons)
`define LBBD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/lbbd_pkg.sv =====
// Types and constants for the LED blink/breathe driver.
// No dependencies.
package lbbd_pkg;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_ON    = 2'd1,
        MODE_BLINK = 2'd2,
        MODE_FADE  = 2'd3
    } t_mode;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE  = 2'd2;

    localparam logic [7:0]  LEVEL_FULL  = 8'hFF;
    localparam logic [7:0]  LEVEL_DARK  = 8'h00;
    localparam logic [15:0] BLINK_RESET = 16'd500;
    localparam logic [15:0] FADE_RESET  = 16'd10;

endpackage

// ===== rtl/led_blink_breathe_driver.sv =====
// Single-channel LED drive level controller: off, on, blink and triangle fade.
// Depends on lbbd_pkg and led_blink_breathe_driver_macros.svh.
// Results are registered. Throughput: one sample per cycle while o_in_stall
// is low; the stamp compare and the state update are combinational into the
// state registers, so the state loop sets the rate. A two-entry output buffer
// (result register plus skid) takes one more sample while the output stalls.
// Reset is synchronous, active low: registers go to their reset values and
// both output entries empty.
`include "led_blink_breathe_driver_macros.svh"

module led_blink_breathe_driver (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lbbd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lbbd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [31:0]                      i_now_ms,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [7:0]                       o_level,
    output logic                             o_written
);
    import lbbd_pkg::*;

    t_mode       r_mode;
    logic [15:0] r_blink_interval;
    logic [15:0] r_fade_period;

    logic        r_blink_on;
    logic [31:0] r_blink_stamp;
    logic [31:0] r_fade_stamp;
    logic [7:0]  r_fade_level;
    logic        r_fade_rising;
    logic [7:0]  r_held_level;

    logic        r_out_valid;
    logic [7:0]  r_out_level;
    logic        r_out_written;
    logic        r_skid_valid;
    logic [7:0]  r_skid_level;
    logic        r_skid_written;

    logic        n_blink_on;
    logic [31:0] n_blink_stamp;
    logic [31:0] n_fade_stamp;
    logic [7:0]  n_fade_level;
    logic        n_fade_rising;
    logic [7:0]  n_held_level;
    logic        n_written;

    logic [31:0] blink_elapsed;
    logic [31:0] fade_elapsed;
    logic        blink_due;
    logic        fade_due;
    logic        in_acc;
    logic        out_free;

    assign in_acc   = i_in_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_out_stall;

    assign blink_elapsed = i_now_ms - r_blink_stamp;
    assign fade_elapsed  = i_now_ms - r_fade_stamp;
    assign blink_due     = blink_elapsed >= {16'd0, r_blink_interval};
    assign fade_due      = fade_elapsed >= {16'd0, r_fade_period};

    always_comb begin
        n_blink_on    = r_blink_on;
        n_blink_stamp = r_blink_stamp;
        n_fade_stamp  = r_fade_stamp;
        n_fade_level  = r_fade_level;
        n_fade_rising = r_fade_rising;
        n_held_level  = r_held_level;
        n_written     = 1'b0;
        case (r_mode)
            MODE_OFF: begin
                n_held_level = LEVEL_DARK;
                n_written    = 1'b1;
            end
            MODE_ON: begin
                n_held_level = LEVEL_FULL;
                n_written    = 1'b1;
            end
            MODE_BLINK: begin
                if (blink_due) begin
                    n_blink_on    = !r_blink_on;
                    n_held_level  = r_blink_on ? LEVEL_DARK : LEVEL_FULL;
                    n_blink_stamp = i_now_ms;
                    n_written     = 1'b1;
                end
            end
            MODE_FADE: begin
                if (fade_due) begin
                    // Turn round at either end without moving the level.
                    if (r_fade_rising) begin
                        if (r_fade_level == LEVEL_FULL) begin
                            n_fade_rising = 1'b0;
                        end else begin
                            n_fade_level = r_fade_level + 8'd1;
                        end
                    end else begin
                        if (r_fade_level == LEVEL_DARK) begin
                            n_fade_rising = 1'b1;
                        end else begin
                            n_fade_level = r_fade_level - 8'd1;
                        end
                    end
                    n_held_level = n_fade_level;
                    n_fade_stamp = i_now_ms;
                    n_written    = 1'b1;
                end
            end
            default: begin
                n_written = 1'b0;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode           <= MODE_OFF;
            r_blink_interval <= BLINK_RESET;
            r_fade_period    <= FADE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:  r_mode           <= t_mode'(i_cfg_data[1:0]);
                CFG_BLINK: r_blink_interval <= i_cfg_data;
                CFG_FADE:  r_fade_period    <= i_cfg_data;
                default:   r_mode           <= r_mode;
            endcase
        end
    end

    // Channel state advances on every accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_on    <= 1'b1;
            r_blink_stamp <= '0;
            r_fade_stamp  <= '0;
            r_fade_level  <= LEVEL_DARK;
            r_fade_rising <= 1'b0;
            r_held_level  <= LEVEL_DARK;
        end else if (in_acc) begin
            r_blink_on    <= n_blink_on;
            r_blink_stamp <= n_blink_stamp;
            r_fade_stamp  <= n_fade_stamp;
            r_fade_level  <= n_fade_level;
            r_fade_rising <= n_fade_rising;
            r_held_level  <= n_held_level;
        end
    end

    // Output valid flags: skid fills only while the result register is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || in_acc;
            r_skid_valid <= 1'b0;
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_level   <= r_skid_level;
                r_out_written <= r_skid_written;
            end else if (in_acc) begin
                r_out_level   <= n_held_level;
                r_out_written <= n_written;
            end
        end else if (in_acc) begin
            r_skid_level   <= n_held_level;
            r_skid_written <= n_written;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_level     = r_out_level;
    assign o_written   = r_out_written;

    `LBBD_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid)
    `LBBD_ASSERT_NEXT(a_blink_full_or_dark, in_acc && r_mode == MODE_BLINK && blink_due, r_held_level == LEVEL_FULL || r_held_level == LEVEL_DARK)
    `LBBD_ASSERT_NOW(a_fade_one_step, $past(i_rst_n), (r_fade_level - $past(r_fade_level)) == 8'd0 || (r_fade_level - $past(r_fade_level)) == 8'd1 || (r_fade_level - $past(r_fade_level)) == 8'hFF)
    `LBBD_ASSERT_NEXT(a_fixed_mode_writes, in_acc && (r_mode == MODE_OFF || r_mode == MODE_ON), r_out_valid && (r_skid_valid ? r_skid_written : r_out_written))

endmodule
